/* design/aabd_pkg.sv */
package aabd_pkg;

  // register indexes (paddr bit 2)
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_BLOCK_HEIGHT = 1'b1;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [4:0]  BLOCK_HEIGHT_RST = 5'd8;

  // gray = floor((30r + 59g + 11b) / 100), done as a reciprocal multiply
  localparam int unsigned GRAY_SHIFT = 21;
  localparam logic [14:0] GRAY_MUL   = 15'd20972;

  // avg = floor(sum / (2*bw*bw)) = (sum * RECIP_TBL[bw-1]) >> RECIP_SHIFT
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
    26'((33554432 +   0) /   1), 26'((33554432 +   3) /   4),
    26'((33554432 +   8) /   9), 26'((33554432 +  15) /  16),
    26'((33554432 +  24) /  25), 26'((33554432 +  35) /  36),
    26'((33554432 +  48) /  49), 26'((33554432 +  63) /  64),
    26'((33554432 +  80) /  81), 26'((33554432 +  99) / 100),
    26'((33554432 + 120) / 121), 26'((33554432 + 143) / 144),
    26'((33554432 + 168) / 169), 26'((33554432 + 195) / 196),
    26'((33554432 + 224) / 225), 26'((33554432 + 255) / 256)
  };

  // lowest level of each ramp step above the first
  localparam logic [7:0] RAMP_THR [9] = '{
    8'd13, 8'd39, 8'd64, 8'd90, 8'd115, 8'd141, 8'd166, 8'd192, 8'd217
  };

  // " .:-=+*#%@"
  localparam logic [6:0] RAMP_CODES [10] = '{
    7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
  };

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [6:0] symbol;
    logic [7:0] level;
    logic       line_end;
  } res_t;

  function automatic logic [6:0] ramp_code(input logic [7:0] level);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 9; i++) begin
      if (level >= RAMP_THR[i]) idx = idx + 4'd1;
    end
    return RAMP_CODES[idx];
  endfunction

endpackage

/* design/ascii_art_block_downscaler_unit.sv */
// Block-average downscaler with an ASCII brightness ramp.
//
// Input stream: one RGB pixel per item in raster order. s_axis_tdata holds
// red, green, blue; s_axis_tuser flags the first pixel of a frame, which
// restarts the position counters. Output stream: one item per full block,
// the ramp character, the block's average gray level, and tlast on the last
// block of a text row. Partial blocks at the right and bottom are dropped.
//
// A block result passes the gray multiply, the line-store read-modify-write
// and the reciprocal multiply, then is written to the output queue. Pixels
// go in one per cycle while the queue has room, except in the last row of
// a block row with one-pixel blocks, where every pixel makes an item. A
// four-item output queue keeps taking pixels while the receiver stalls;
// tready drops only when the queue plus results still in the pipeline fill
// it. Column sums live in a line store with a registered read port.
//
// APB registers: 0x0 image_width, 0x4 block_height. Writing either restarts
// the position counters. Reset sets 640 and 8 and clears all counters; the
// line store needs no clearing since the first row of each block overwrites.
module ascii_art_block_downscaler_unit #(
  parameter int MAX_WIDTH        = 1024,
  parameter int MAX_BLOCK_HEIGHT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic [0:0]  s_axis_tuser,   // start_of_frame[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // symbol[6:0], level[14:7], zero[15]
  output logic        m_axis_tlast,   // line_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HALF  = MAX_BLOCK_HEIGHT / 2;
  localparam int TOP_H = HALF * 2;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH + MAX_BLOCK_HEIGHT + 1) + 1;
  localparam int PC_W  = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int BW_W  = $clog2(HALF + 1);
  localparam int RIB_W = $clog2(TOP_H);
  localparam int RP_W  = $clog2(255 * HALF + 1);
  localparam int SUM_W = $clog2(255 * TOP_H * HALF + 1);
  localparam int PR_W  = SUM_W + aabd_pkg::RECIP_W;
  localparam int PTR_W = $clog2(aabd_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(aabd_pkg::FIFO_DEPTH + 1);

  typedef struct packed {
    logic          en;
    logic          fresh;
    logic          close;
    logic          use_mem;
    logic          last;
    logic          line_end;
    logic [AW-1:0] addr;
  } cmd_t;

  // configuration
  logic [10:0] image_width_q, image_width_d;
  logic [4:0]  block_height_q, block_height_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    image_width_d  = image_width_q;
    block_height_d = block_height_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        aabd_pkg::CFG_IMAGE_WIDTH:  image_width_d  = pwdata[10:0];
        aabd_pkg::CFG_BLOCK_HEIGHT: block_height_d = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      aabd_pkg::CFG_IMAGE_WIDTH:  prdata = {21'b0, image_width_q};
      aabd_pkg::CFG_BLOCK_HEIGHT: prdata = {27'b0, block_height_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= aabd_pkg::IMAGE_WIDTH_RST;
      block_height_q <= aabd_pkg::BLOCK_HEIGHT_RST;
    end else begin
      image_width_q  <= image_width_d;
      block_height_q <= block_height_d;
    end
  end

  // effective geometry
  logic [WW-1:0]   eff_w;
  logic [BW_W-1:0] eff_bw;
  logic [BW_W:0]   eff_h;

  always_comb begin
    if (image_width_q < 11'd2) begin
      eff_w = WW'(2);
    end else if ({21'b0, image_width_q} > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_q);
    end
    if (block_height_q[4:1] == 4'd0) begin
      eff_bw = BW_W'(1);
    end else if ({28'b0, block_height_q[4:1]} > 32'(HALF)) begin
      eff_bw = BW_W'(HALF);
    end else begin
      eff_bw = BW_W'(block_height_q[4:1]);
    end
    eff_h = {eff_bw, 1'b0};
  end

  // position counters
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [BW_W-1:0]  cib_q, cib_d;
  logic [AW-1:0]    bc_q, bc_d;
  logic [RIB_W-1:0] rib_q, rib_d;

  logic             s_acc;
  logic             sof;
  logic [PC_W-1:0]  pc0;
  logic [BW_W-1:0]  cib0;
  logic [AW-1:0]    bc0;
  logic [RIB_W-1:0] rib0;
  logic [XW-1:0]    blk_start;
  logic             st_fit, st_close, st_last, st_le, row_done;
  cmd_t             cmd;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign sof   = s_axis_tuser[0];

  always_comb begin
    pc0       = sof ? '0 : pc_q;
    cib0      = sof ? '0 : cib_q;
    bc0       = sof ? '0 : bc_q;
    rib0      = sof ? '0 : rib_q;
    blk_start = XW'(pc0) - XW'(cib0);
    st_fit    = (blk_start + XW'(eff_bw)) <= XW'(eff_w);
    st_le     = (blk_start + XW'(eff_h)) > XW'(eff_w);
    st_close  = st_fit && ((cib0 + BW_W'(1)) == eff_bw);
    st_last   = ((RIB_W + 1)'(rib0) + (RIB_W + 1)'(1)) >= eff_h;
    row_done  = (XW'(pc0) + XW'(1)) >= XW'(eff_w);

    cmd.en       = st_fit;
    cmd.fresh    = (cib0 == '0);
    cmd.close    = st_close;
    cmd.use_mem  = (rib0 != '0);
    cmd.last     = st_last;
    cmd.line_end = st_le;
    cmd.addr     = bc0;
  end

  always_comb begin
    pc_d  = pc_q;
    cib_d = cib_q;
    bc_d  = bc_q;
    rib_d = rib_q;
    if (cfg_wr) begin
      pc_d  = '0;
      cib_d = '0;
      bc_d  = '0;
      rib_d = '0;
    end else if (s_acc) begin
      if (row_done) begin
        pc_d  = '0;
        cib_d = '0;
        bc_d  = '0;
        rib_d = st_last ? '0 : rib0 + RIB_W'(1);
      end else begin
        pc_d  = pc0 + PC_W'(1);
        rib_d = rib0;
        cib_d = cib0;
        bc_d  = bc0;
        if (st_fit) begin
          cib_d = st_close ? '0 : cib0 + BW_W'(1);
          bc_d  = st_close ? bc0 + AW'(1) : bc0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      cib_q <= '0;
      bc_q  <= '0;
      rib_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cib_q <= cib_d;
      bc_q  <= bc_d;
      rib_q <= rib_d;
    end
  end

  // stage 1: gray multiply, line store read
  logic [14:0]      y;
  logic [29:0]      p1_q;
  logic             v1_q;
  cmd_t             c1_q;
  logic             mem_re, mem_we;
  logic [SUM_W-1:0] mem_rdata_q;
  logic [SUM_W-1:0] col_mem [MAX_WIDTH];

  assign y = 15'(16'd30 * s_axis_tdata[7:0] + 16'd59 * s_axis_tdata[15:8]
               + 16'd11 * s_axis_tdata[23:16]);
  assign mem_re = s_acc && st_close && (rib0 != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_q <= 30'(y) * 30'(aabd_pkg::GRAY_MUL);
      c1_q <= cmd;
    end
  end

  // stage 2: row and column accumulation; a read and a write to the same
  // entry are always at least one row apart, so no forwarding is needed
  logic [7:0]       gray;
  logic [RP_W-1:0]  rp_q, rsum;
  logic [SUM_W-1:0] bsum, sum2_q;
  logic             v2_q, le2_q;

  assign gray   = p1_q[aabd_pkg::GRAY_SHIFT +: 8];
  assign rsum   = (c1_q.fresh ? '0 : rp_q) + RP_W'(gray);
  assign bsum   = SUM_W'(rsum) + (c1_q.use_mem ? mem_rdata_q : '0);
  assign mem_we = v1_q && c1_q.en && c1_q.close && !c1_q.last;

  always_ff @(posedge clk_i) begin
    if (mem_we) col_mem[c1_q.addr] <= bsum;
    if (mem_re) mem_rdata_q <= col_mem[bc0];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && c1_q.en && !c1_q.close) rp_q <= rsum;
    if (v1_q) begin
      sum2_q <= bsum;
      le2_q  <= c1_q.line_end;
    end
  end

  // stage 3: reciprocal multiply
  logic            v3_q, le3_q;
  logic [PR_W-1:0] prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= v1_q && c1_q.en && c1_q.close && c1_q.last;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      prod3_q <= PR_W'(sum2_q) * PR_W'(aabd_pkg::RECIP_TBL[4'(eff_bw - BW_W'(1))]);
      le3_q   <= le2_q;
    end
  end

  // output queue
  aabd_pkg::res_t   fifo_q [aabd_pkg::FIFO_DEPTH];
  aabd_pkg::res_t   res;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] pend;
  logic             pop;

  always_comb begin
    res.level    = prod3_q[aabd_pkg::RECIP_SHIFT +: 8];
    res.symbol   = aabd_pkg::ramp_code(res.level);
    res.line_end = le3_q;
  end

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign pend = CNT_W'(v1_q && c1_q.en && c1_q.close && c1_q.last)
              + CNT_W'(v2_q) + CNT_W'(v3_q);
  assign s_axis_tready = (cnt_q + pend) < CNT_W'(aabd_pkg::FIFO_DEPTH);
  assign cnt_d = cnt_q + CNT_W'(v3_q) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (v3_q) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) fifo_q[wr_ptr_q] <= res;
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {1'b0, fifo_q[rd_ptr_q].level, fifo_q[rd_ptr_q].symbol};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].line_end;

endmodule

/* design/aabd_checker.sv */
module aabd_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        pready
);

  // a waiting item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // symbol follows from level, and bit 15 stays zero
  a_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[6:0] == aabd_pkg::ramp_code(m_axis_tdata[14:7]) &&
      !m_axis_tdata[15])
    else $error("symbol does not match level");

  // a result that first shows must follow an accepted pixel
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("output item without a matching input item");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low");

endmodule

bind ascii_art_block_downscaler_unit aabd_sva u_aabd_sva (.*);
